@@ sv/mbe_pkg.sv @@
package mbe_pkg;

  localparam int FRACTION_BITS = 28;
  localparam int COORD_BITS    = 12;

  localparam int PIX_W    = 12;
  localparam int MAX_W    = 12;
  localparam int ORG_W    = 32;
  localparam int STEP_W   = 31;
  localparam int BRIGHT_W = 8;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 32;
  localparam int IN_W     = 2 * PIX_W;
  localparam int OUT_W    = 24;
  localparam int OUT_PAD  = OUT_W - MAX_W - BRIGHT_W;

  // c straight from the pixel mapping, before the range check
  localparam int MAP_W  = COORD_BITS + STEP_W + 2;
  // z and c once inside |v| <= 2
  localparam int Z_W    = FRACTION_BITS + 3;
  // floored square of a value inside |v| <= 2
  localparam int SQ_W   = FRACTION_BITS + 3;
  // new iterate before its range check
  localparam int N_W    = FRACTION_BITS + 6;
  localparam int PROD_W = 2 * Z_W;
  localparam int REM_W  = MAX_W + BRIGHT_W;
  localparam int DCNT_W = 3;

  localparam logic [MAX_W-1:0]  MAX_ITER_RESET    = 12'd1000;
  localparam logic [ORG_W-1:0]  REAL_ORIGIN_RESET = 32'hD800_0000;
  localparam logic [STEP_W-1:0] REAL_STEP_RESET   = 31'd1174405;
  localparam logic [ORG_W-1:0]  IMAG_ORIGIN_RESET = 32'hF000_0000;
  localparam logic [STEP_W-1:0] IMAG_STEP_RESET   = 31'd894785;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_ITER    = 3'd0,
    REG_REAL_ORIGIN = 3'd1,
    REG_REAL_STEP   = 3'd2,
    REG_IMAG_ORIGIN = 3'd3,
    REG_IMAG_STEP   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [MAX_W-1:0]  max_iter;
    logic [ORG_W-1:0]  real_origin;
    logic [STEP_W-1:0] real_step;
    logic [ORG_W-1:0]  imag_origin;
    logic [STEP_W-1:0] imag_step;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_INIT,
    ST_SQUARE,
    ST_TEST,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic map;
    logic init;
    logic square;
    logic test;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic c_out;
    logic z_out;
    logic sum_esc;
    logic at_limit;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

@@ sv/mandelbrot_escape_time_pixel.sv @@
// Escape-time evaluation of one pixel at a time, in iteration rounds
// (square step, then escape test with the cross product) in one shared datapath.
// The brightness comes from a restoring divider on N, the final count; when c starts
// outside |re|, |im| <= 2 the iteration rounds are skipped.
// Next pixel is taken the cycle after the result loads.
// Synchronous active-high reset clears the controller and output valid and loads defaults.
module mandelbrot_escape_time_pixel
  import mbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // pixel_x, pixel_y
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // brightness, iteration_count, zero pad
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  mbe_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg_valid),
    .wr_ready (cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mbe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixel_x   (s_axis_tdata[PIX_W-1:0]),
    .pixel_y   (s_axis_tdata[PIX_W +: PIX_W]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

@@ sv/mbe_cfg.sv @@
module mbe_cfg
  import mbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output cfg_t             cfg
);

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_iter    <= MAX_ITER_RESET;
      cfg.real_origin <= REAL_ORIGIN_RESET;
      cfg.real_step   <= REAL_STEP_RESET;
      cfg.imag_origin <= IMAG_ORIGIN_RESET;
      cfg.imag_step   <= IMAG_STEP_RESET;
    end else if (wr_valid && wr_ready) begin
      case (cfg_reg_t'(wr_index))
        REG_MAX_ITER:    cfg.max_iter    <= wr_data[MAX_W-1:0];
        REG_REAL_ORIGIN: cfg.real_origin <= wr_data[ORG_W-1:0];
        REG_REAL_STEP:   cfg.real_step   <= wr_data[STEP_W-1:0];
        REG_IMAG_ORIGIN: cfg.imag_origin <= wr_data[ORG_W-1:0];
        REG_IMAG_STEP:   cfg.imag_step   <= wr_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/mbe_ctrl.sv @@
module mbe_ctrl
  import mbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map    = 1'b1;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = status.c_out ? ST_DIV_LOAD : ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = status.z_out ? ST_DIV_LOAD : ST_TEST;
      end
      ST_TEST: begin
        cmd.test   = 1'b1;
        state_next = (status.sum_esc || status.at_limit) ? ST_DIV_LOAD : ST_SQUARE;
      end
      ST_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ sv/mbe_dp.sv @@
module mbe_dp
  import mbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic [PIX_W-1:0] pixel_x,
  input  logic [PIX_W-1:0] pixel_y,
  input  cmd_t             cmd,
  output status_t          status,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  localparam logic signed [MAP_W-1:0] TWO_MAP = MAP_W'(64'sd1 <<< (FRACTION_BITS + 1));
  localparam logic signed [N_W-1:0]   TWO_N   = N_W'(64'sd1 <<< (FRACTION_BITS + 1));
  localparam logic [SQ_W:0]           FOUR    = (SQ_W + 1)'(64'd1 << (FRACTION_BITS + 2));

  logic [COORD_BITS-1:0] px, py;
  logic signed [MAP_W-1:0] map_re, map_im;
  logic signed [Z_W-1:0]   cr, ci, zr, zi;
  logic [SQ_W-1:0]         sr, si;
  logic signed [N_W-1:0]   nr, ni;
  logic [MAX_W-1:0]        n;
  logic                    first;
  logic [REM_W-1:0]        rem;
  logic [BRIGHT_W-1:0]     quo;
  logic [DCNT_W-1:0]       div_cnt;
  logic [BRIGHT_W-1:0]     out_bright;
  logic [MAX_W-1:0]        out_count;

  logic [COORD_BITS+STEP_W-1:0] prod_re, prod_im;
  logic signed [MAP_W-1:0]      map_re_next, map_im_next;
  logic signed [Z_W-1:0]        sq_re, sq_im;
  logic signed [PROD_W-1:0]     sq_prod_re, sq_prod_im, cross_prod;
  logic [SQ_W:0]                sum;
  logic [MAX_W-1:0]             n_new;
  logic signed [N_W-1:0]        nr_next, ni_next, cr_n, ci_n;
  logic [REM_W-1:0]             dshift, dividend;
  logic                         take;

  // pixel to c
  assign prod_re = px * cfg.real_step;
  assign prod_im = py * cfg.imag_step;
  assign map_re_next = $signed({{(MAP_W-ORG_W){cfg.real_origin[ORG_W-1]}}, cfg.real_origin})
                     + $signed({2'b00, prod_re});
  assign map_im_next = $signed({{(MAP_W-ORG_W){cfg.imag_origin[ORG_W-1]}}, cfg.imag_origin})
                     + $signed({2'b00, prod_im});

  // first square pass works on c itself, later passes on the new iterate
  assign sq_re = first ? zr : $signed(nr[Z_W-1:0]);
  assign sq_im = first ? zi : $signed(ni[Z_W-1:0]);
  assign sq_prod_re = sq_re * sq_re;
  assign sq_prod_im = sq_im * sq_im;

  assign sum   = {1'b0, sr} + {1'b0, si};
  assign n_new = first ? n : n + 1'b1;

  // floor(2*zr*zi): one less bit of shift
  assign cross_prod = zr * zi;
  assign cr_n    = $signed({{(N_W-Z_W){cr[Z_W-1]}}, cr});
  assign ci_n    = $signed({{(N_W-Z_W){ci[Z_W-1]}}, ci});
  assign nr_next = $signed({{(N_W-SQ_W){1'b0}}, sr}) - $signed({{(N_W-SQ_W){1'b0}}, si}) + cr_n;
  assign ni_next = $signed(cross_prod[FRACTION_BITS-1 +: N_W]) + ci_n;

  // restoring divide, quotient known to fit in eight bits
  assign dividend = (n == cfg.max_iter) ? '0
                  : ({n, {BRIGHT_W{1'b0}}} - {{BRIGHT_W{1'b0}}, n});
  assign dshift   = {{BRIGHT_W{1'b0}}, cfg.max_iter} << div_cnt;
  assign take     = (cfg.max_iter != '0) && (rem >= dshift);

  assign status.c_out    = (map_re > TWO_MAP) || (map_re < -TWO_MAP)
                        || (map_im > TWO_MAP) || (map_im < -TWO_MAP);
  assign status.z_out    = !first && ((nr > TWO_N) || (nr < -TWO_N)
                        || (ni > TWO_N) || (ni < -TWO_N));
  assign status.sum_esc  = sum > FOUR;
  assign status.at_limit = n_new >= cfg.max_iter;
  assign status.div_last = div_cnt == '0;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px <= pixel_x[COORD_BITS-1:0];
      py <= pixel_y[COORD_BITS-1:0];
      n  <= '0;
    end
    if (cmd.map) begin
      map_re <= map_re_next;
      map_im <= map_im_next;
    end
    if (cmd.init) begin
      cr    <= map_re[Z_W-1:0];
      ci    <= map_im[Z_W-1:0];
      zr    <= map_re[Z_W-1:0];
      zi    <= map_im[Z_W-1:0];
      first <= 1'b1;
    end
    if (cmd.square) begin
      sr <= sq_prod_re[FRACTION_BITS +: SQ_W];
      si <= sq_prod_im[FRACTION_BITS +: SQ_W];
      zr <= sq_re;
      zi <= sq_im;
    end
    if (cmd.test) begin
      if (!status.sum_esc) begin
        n     <= n_new;
        first <= 1'b0;
      end
      nr <= nr_next;
      ni <= ni_next;
    end
    if (cmd.div_start) begin
      rem     <= dividend;
      quo     <= '0;
      div_cnt <= DCNT_W'(BRIGHT_W - 1);
    end else if (cmd.div_step) begin
      if (take) begin
        rem          <= rem - dshift;
        quo[div_cnt] <= 1'b1;
      end
      div_cnt <= div_cnt - 1'b1;
    end
    if (cmd.out_load) begin
      out_bright <= quo;
      out_count  <= n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {{OUT_PAD{1'b0}}, out_count, out_bright};

endmodule

@@ sv/mbe_checker.sv @@
module mbe_checker
  import mbe_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // one pixel in flight: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a pixel is in flight");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // count < max gives quotient at most 254
  a_bright_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[BRIGHT_W-1:0] != {BRIGHT_W{1'b1}})
    else $error("brightness out of range");

  a_bright_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[BRIGHT_W-1:0] != '0)
      |-> (m_axis_tdata[BRIGHT_W +: MAX_W] != '0))
    else $error("nonzero brightness with zero count");

endmodule

bind mandelbrot_escape_time_pixel mbe_checker u_checker (.*);
